/* rtl/lpmrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmrb_pkg: shared constants, types and tables of the polar binner.
// Fixed-point formats, CORDIC arctangent table and bin arithmetic constants.
// ----------------------------------------------------------------------------
package lpmrb_pkg;

  localparam int ANGLE_BINS   = 720;
  localparam int RANGE_WIDTH  = 17;
  localparam int HALF_BINS    = ANGLE_BINS / 2;
  localparam int IDX_W        = $clog2(ANGLE_BINS);
  localparam int RANGE_MAX    = (1 << RANGE_WIDTH) - 1;
  localparam int RESET_RANGE  = (10000 > RANGE_MAX) ? RANGE_MAX : 10000;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int CW           = (RANGE_WIDTH + 10 > 27) ? RANGE_WIDTH + 10 : 27;
  localparam int ZW           = 34;
  localparam int PW           = CW + 32;
  localparam int GAIN_SHIFT   = 40;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam longint PI_TURN      = 64'sd2147483648;
  localparam longint HALF_PI_TURN = 64'sd1073741824;

  localparam longint unsigned TURN     = 64'd1 << 32;
  localparam longint unsigned BIN_STEP = TURN / ANGLE_BINS;
  localparam longint unsigned BIN_REM  = TURN % ANGLE_BINS;
  localparam int              RECIP_SHIFT = 40;
  localparam longint unsigned RECIP    = ((64'd1 << RECIP_SHIFT) / ANGLE_BINS) + 64'd1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctrl_t;

  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/lpmrb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmrb_if: request channels of the polar binner.
// Input channel carries commands and points, output channel carries bin reads.
// ----------------------------------------------------------------------------
interface lpmrb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [16:0] point_x;
  logic signed [16:0] point_y;
  logic signed [9:0]  read_bin;
  modport source (output valid, cmd, point_x, point_y, read_bin, input ready);
  modport sink   (input valid, cmd, point_x, point_y, read_bin, output ready);
endinterface

interface lpmrb_out_if;
  logic              valid;
  logic              ready;
  logic signed [9:0]  bin_index;
  logic [16:0]       range_mm;
  logic signed [17:0] out_x;
  logic signed [17:0] out_y;
  modport source (output valid, bin_index, range_mm, out_x, out_y, input ready);
  modport sink   (input valid, bin_index, range_mm, out_x, out_y, output ready);
endinterface

/* rtl/lpmrb_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmrb_cordic: iterative CORDIC, one micro-rotation per cycle.
// Vectoring drives v to zero, rotation drives z to zero; done pulses at the end.
// ----------------------------------------------------------------------------
module lpmrb_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  lpmrb_pkg::cordic_ctrl_t          ctrl,
  input  logic signed [lpmrb_pkg::CW-1:0]  u_init,
  input  logic signed [lpmrb_pkg::CW-1:0]  v_init,
  input  logic signed [lpmrb_pkg::ZW-1:0]  z_init,
  output logic                             done,
  output logic signed [lpmrb_pkg::CW-1:0]  u_res,
  output logic signed [lpmrb_pkg::CW-1:0]  v_res,
  output logic signed [lpmrb_pkg::ZW-1:0]  z_res
);
  import lpmrb_pkg::*;

  logic              busy;
  logic              rotate;
  logic [STEP_W-1:0] step;
  logic signed [CW-1:0] du;
  logic signed [CW-1:0] dv;
  logic signed [ZW-1:0] a;
  logic                 pos;

  assign du  = v_res >>> step;
  assign dv  = u_res >>> step;
  assign a   = signed'(ZW'(atan_turn(step)));
  assign pos = rotate ? !z_res[ZW-1] : !v_res[CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !ctrl.start && (step == STEP_W'(CORDIC_STEPS - 1));
      if (ctrl.start) begin
        busy   <= 1'b1;
        rotate <= ctrl.rotate;
        step   <= '0;
        u_res  <= u_init;
        v_res  <= v_init;
        z_res  <= z_init;
      end else if (busy) begin
        if (rotate) begin
          if (pos) begin
            u_res <= u_res - du;
            v_res <= v_res + dv;
            z_res <= z_res - a;
          end else begin
            u_res <= u_res + du;
            v_res <= v_res - dv;
            z_res <= z_res + a;
          end
        end else begin
          if (pos) begin
            u_res <= u_res + du;
            v_res <= v_res - dv;
            z_res <= z_res + a;
          end else begin
            u_res <= u_res - du;
            v_res <= v_res + dv;
            z_res <= z_res - a;
          end
        end
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/lidar_polar_min_range_binner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_polar_min_range_binner_unit: lidar point binner by angle, minimum range.
// Converts points to polar form and keeps the minimum range per angle bin.
// ----------------------------------------------------------------------------
// The input channel takes one request at a time: add point, close frame or
// read bin. An add point request keeps the block busy, after it is taken,
// through the CORDIC, a gain multiply, bin rounding and a read-modify-write
// of the bin memories. A point at the origin skips the CORDIC and the gain
// multiply; a dropped point ends after bin rounding, without a memory write.
// A close frame request sweeps the touched-flag memory, one bin a cycle.
// A read request runs a memory read, the bin-centre angle, 30 rotating CORDIC
// iterations and two gain multiplies on one shared multiplier.
// Only reads of a valid bin produce a request on the output channel.
// After reset a pass writes 10000 mm and a clear flag into every bin; no
// request is taken until it ends. A result waits in the output register
// while the receiver stalls; a new request is still taken then, and a
// following read holds at its last step until the register is free.
// ----------------------------------------------------------------------------
module lidar_polar_min_range_binner_unit (
  input  logic clk,
  input  logic rst,
  lpmrb_in_if.sink    in_ch,
  lpmrb_out_if.source out_ch
);
  import lpmrb_pkg::*;

  localparam int AM_W = ZW + IDX_W;
  localparam int BW   = AM_W - 32;
  localparam int RW   = PW - GAIN_SHIFT;
  localparam int N_W  = 2 * IDX_W + 2;
  localparam int RP_W = N_W + 40;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_PT_PRE, S_PT_CORDIC, S_PT_GAIN, S_PT_IDX, S_PT_RD,
    S_PT_WR, S_RD_Z1, S_RD_Z2, S_RD_Z3, S_RD_CORDIC, S_RD_MX, S_RD_MY, S_RD_PUSH
  } state_t;

  state_t state;
  logic [IDX_W-1:0] sweep_cnt;
  logic signed [16:0] px;
  logic signed [16:0] py;
  logic signed [9:0]  bin_q;
  logic               bin_neg;
  logic [IDX_W-1:0]   bin_mag;
  logic [RANGE_WIDTH-1:0] rng_q;
  logic [PW-1:0]      prod;
  logic               mul_neg;
  logic               ang_neg;
  logic [AM_W-1:0]    angmul;
  logic [IDX_W-1:0]   pt_idx;
  logic [ZW-2:0]      zi;
  logic [N_W-1:0]     nval;
  logic [IDX_W:0]     frac;
  logic [17:0]        x_res;

  logic               out_valid;
  logic signed [9:0]  out_bin;
  logic [16:0]        out_rng;
  logic signed [17:0] out_xq;
  logic signed [17:0] out_yq;

  logic [RANGE_WIDTH-1:0] range_mem [ANGLE_BINS];
  logic                   touched_mem [ANGLE_BINS];
  logic [RANGE_WIDTH-1:0] range_rd;
  logic                   touched_rd;
  logic [IDX_W-1:0]       mem_ra;
  logic [IDX_W-1:0]       mem_wa;
  logic                   range_we;
  logic                   touched_we;
  logic [RANGE_WIDTH-1:0] range_wd;
  logic                   touched_wd;

  cordic_ctrl_t         cctrl;
  logic signed [CW-1:0] cu_init;
  logic signed [CW-1:0] cv_init;
  logic signed [ZW-1:0] cz_init;
  logic                 c_done;
  logic signed [CW-1:0] u_res;
  logic signed [CW-1:0] v_res;
  logic signed [ZW-1:0] z_res;

  logic [CW-1:0]    abs_u;
  logic [CW-1:0]    abs_v;
  logic [CW-1:0]    mul_a;
  logic [PW-1:0]    rnd_full;
  logic [RW-1:0]    rnd;
  logic [RW-1:0]    srnd;
  logic [RANGE_WIDTH-1:0] rng_sat;
  logic [AM_W-1:0]  badd;
  logic [BW-1:0]    b;
  logic             pt_drop;
  logic [ZW-2:0]    zmag;
  logic signed [ZW-1:0] zr;
  logic [RP_W-1:0]  rprod;
  logic             rd_ok;
  logic [ZW-2:0]    abs_z;

  lpmrb_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (cctrl),
    .u_init (cu_init),
    .v_init (cv_init),
    .z_init (cz_init),
    .done   (c_done),
    .u_res  (u_res),
    .v_res  (v_res),
    .z_res  (z_res)
  );

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.bin_index = out_bin;
  assign out_ch.range_mm  = out_rng;
  assign out_ch.out_x     = out_xq;
  assign out_ch.out_y     = out_yq;

  assign abs_u    = u_res[CW-1] ? (~u_res + 1'b1) : u_res;
  assign abs_v    = v_res[CW-1] ? (~v_res + 1'b1) : v_res;
  assign abs_z    = z_res[ZW-1] ? (ZW-1)'(~z_res + 1'b1) : z_res[ZW-2:0];
  assign mul_a    = (state == S_RD_MX) ? abs_v : abs_u;
  assign rnd_full = prod + (PW'(1) << (GAIN_SHIFT - 1));
  assign rnd      = rnd_full[PW-1:GAIN_SHIFT];
  assign srnd     = mul_neg ? (RW'(0) - rnd) : rnd;
  assign rng_sat  = (rnd > RW'(RANGE_MAX)) ? RANGE_WIDTH'(RANGE_MAX) : rnd[RANGE_WIDTH-1:0];
  assign badd     = angmul + (AM_W'(1) << 31);
  assign b        = badd[AM_W-1:32];
  assign pt_drop  = ang_neg ? (b > BW'(HALF_BINS)) : (b >= BW'(HALF_BINS));
  assign zmag     = zi + (ZW-1)'(frac);
  assign zr       = bin_neg ? (ZW'(0) - ZW'(zmag)) : ZW'(zmag);
  assign rprod    = RP_W'(nval) * RP_W'(RECIP);
  assign rd_ok    = (int'(in_ch.read_bin) >= -HALF_BINS) && (int'(in_ch.read_bin) < HALF_BINS);

  always_comb begin
    cctrl   = '0;
    cu_init = '0;
    cv_init = '0;
    cz_init = '0;
    if (state == S_PT_PRE) begin
      cctrl.start = !(px == '0 && py == '0);
      if (py[16]) begin
        cu_init = ~{{(CW-25){py[16]}}, py, 8'd0} + 1'b1;
        cv_init = ~{{(CW-25){px[16]}}, px, 8'd0} + 1'b1;
        cz_init = px[16] ? -ZW'(PI_TURN) : ZW'(PI_TURN);
      end else begin
        cu_init = {{(CW-25){py[16]}}, py, 8'd0};
        cv_init = {{(CW-25){px[16]}}, px, 8'd0};
      end
    end else if (state == S_RD_Z3) begin
      cctrl.start  = 1'b1;
      cctrl.rotate = 1'b1;
      cu_init = {{(CW-RANGE_WIDTH-8){1'b0}}, rng_q, 8'd0};
      cz_init = zr;
      if (zr > ZW'(HALF_PI_TURN)) begin
        cu_init = ~cu_init + 1'b1;
        cz_init = zr - ZW'(PI_TURN);
      end else if (zr < -ZW'(HALF_PI_TURN)) begin
        cu_init = ~cu_init + 1'b1;
        cz_init = zr + ZW'(PI_TURN);
      end
    end
  end

  always_comb begin
    mem_ra     = pt_idx;
    mem_wa     = pt_idx;
    range_we   = 1'b0;
    touched_we = 1'b0;
    range_wd   = rng_q;
    touched_wd = 1'b1;
    unique case (state)
      S_IDLE: begin
        mem_ra = IDX_W'(int'(in_ch.read_bin) + HALF_BINS);
      end
      S_INIT: begin
        mem_wa     = sweep_cnt;
        range_we   = 1'b1;
        touched_we = 1'b1;
        range_wd   = RANGE_WIDTH'(RESET_RANGE);
        touched_wd = 1'b0;
      end
      S_CLEAR: begin
        mem_wa     = sweep_cnt;
        touched_we = 1'b1;
        touched_wd = 1'b0;
      end
      S_PT_WR: begin
        range_we   = 1'b1;
        touched_we = 1'b1;
        range_wd   = (!touched_rd || rng_q < range_rd) ? rng_q : range_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (range_we) begin
      range_mem[mem_wa] <= range_wd;
    end
    range_rd <= range_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (touched_we) begin
      touched_mem[mem_wa] <= touched_wd;
    end
    touched_rd <= touched_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready && state != S_RD_PUSH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT, S_CLEAR: begin
          if (sweep_cnt == IDX_W'(ANGLE_BINS - 1)) begin
            sweep_cnt <= '0;
            state     <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            px      <= in_ch.point_x;
            py      <= in_ch.point_y;
            bin_q   <= in_ch.read_bin;
            bin_neg <= in_ch.read_bin[9];
            bin_mag <= IDX_W'(in_ch.read_bin[9] ? -int'(in_ch.read_bin)
                                                : int'(in_ch.read_bin));
            case (in_ch.cmd)
              CMD_ADD:   state <= S_PT_PRE;
              CMD_CLOSE: state <= S_CLEAR;
              CMD_READ:  state <= rd_ok ? S_RD_Z1 : S_IDLE;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_PT_PRE: begin
          if (px == '0 && py == '0) begin
            prod    <= '0;
            angmul  <= '0;
            ang_neg <= 1'b0;
            state   <= S_PT_IDX;
          end else begin
            state <= S_PT_CORDIC;
          end
        end
        S_PT_CORDIC: begin
          if (c_done) begin
            state <= S_PT_GAIN;
          end
        end
        S_PT_GAIN: begin
          prod    <= PW'(mul_a) * PW'(INV_GAIN);
          angmul  <= AM_W'(abs_z) * AM_W'(ANGLE_BINS);
          ang_neg <= z_res[ZW-1];
          state   <= S_PT_IDX;
        end
        S_PT_IDX: begin
          rng_q  <= rng_sat;
          pt_idx <= ang_neg ? IDX_W'(BW'(HALF_BINS) - b) : IDX_W'(BW'(HALF_BINS) + b);
          state  <= pt_drop ? S_IDLE : S_PT_RD;
        end
        S_PT_RD: begin
          state <= S_PT_WR;
        end
        S_PT_WR: begin
          state <= S_IDLE;
        end
        S_RD_Z1: begin
          rng_q <= range_rd;
          zi    <= (ZW-1)'(longint'(bin_mag) * longint'(BIN_STEP));
          nval  <= N_W'(longint'(bin_mag) * longint'(BIN_REM) + longint'(HALF_BINS));
          state <= S_RD_Z2;
        end
        S_RD_Z2: begin
          frac  <= rprod[RECIP_SHIFT +: IDX_W+1];
          state <= S_RD_Z3;
        end
        S_RD_Z3: begin
          state <= S_RD_CORDIC;
        end
        S_RD_CORDIC: begin
          if (c_done) begin
            state <= S_RD_MX;
          end
        end
        S_RD_MX: begin
          prod    <= PW'(mul_a) * PW'(INV_GAIN);
          mul_neg <= v_res[CW-1];
          state   <= S_RD_MY;
        end
        S_RD_MY: begin
          x_res   <= srnd[17:0];
          prod    <= PW'(mul_a) * PW'(INV_GAIN);
          mul_neg <= u_res[CW-1];
          state   <= S_RD_PUSH;
        end
        S_RD_PUSH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_bin   <= bin_q;
            out_rng   <= 17'(rng_q);
            out_xq    <= x_res;
            out_yq    <= srnd[17:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
